// File: sv/pkdf_pkg.sv
// ----------------------------------------------------------------------------
// Packet dedup address filter package
// Shared constants, codes and types for the duplicate filter.
// ----------------------------------------------------------------------------
package pkdf_pkg;

   // Number of recent keys kept in the history ring.
   localparam int HISTORY_DEPTH = 20;
   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // Field widths.
   localparam int ADDR_W = 32;
   localparam int NUM_W  = 16;
   localparam int TYPE_W = 8;
   localparam int KEY_W  = ADDR_W + NUM_W;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_ADDRESS = 2'd1;

   // Register reset values: "0001" and "1003".
   localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET   = 32'h3030_3031;
   localparam logic [ADDR_W-1:0] GROUP_ADDRESS_RESET = 32'h3130_3033;

   // Verdict codes.
   localparam logic [1:0] VERDICT_NOT_ADDRESSED = 2'd0;
   localparam logic [1:0] VERDICT_DUPLICATE     = 2'd1;
   localparam logic [1:0] VERDICT_NEW           = 2'd2;

   // Message type characters that raise a flag.
   localparam logic [TYPE_W-1:0] TYPE_LOCATION    = 8'h37;
   localparam logic [TYPE_W-1:0] TYPE_INSTRUCTION = 8'h38;
   localparam logic [TYPE_W-1:0] TYPE_DISTANCE    = 8'h41;

   typedef logic [KEY_W-1:0] key_type;

   // Control from the top level to the history ring.
   typedef struct packed {
      logic fire;       // a request moves from the input to the result register
      logic addressed;  // its destination matched one of the accepted addresses
   } lookup_type;

endpackage

// File: sv/packet_dedup_address_filter.sv
// ----------------------------------------------------------------------------
// Packet dedup address filter
// Checks the destination of a received header, rejects repeats of recent
// source and packet number pairs, and reports flags for new packets.
// ----------------------------------------------------------------------------
// The request is held in the input register and its result in the result register,
// which drives rsp_valid.
// Throughput: one request per cycle while rsp_stall is low; the combinational compare
// against all history entries in registers sets this figure.
// Reset (synchronous, active high) empties the history, zeroes the ring
// pointer and location flag, and restores the addresses "0001" and "1003".
module packet_dedup_address_filter (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pkdf_pkg::ADDR_W-1:0]      req_source_address,
   input  logic [pkdf_pkg::ADDR_W-1:0]      req_destination_address,
   input  logic [pkdf_pkg::NUM_W-1:0]       req_packet_number,
   input  logic [pkdf_pkg::TYPE_W-1:0]      req_message_type,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_verdict,
   output logic                             rsp_start_location,
   output logic                             rsp_instruction_seen,
   output logic                             rsp_distance_seen,
   output logic                             rsp_location_enabled,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pkdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pkdf_pkg::ADDR_W-1:0]      csr_data
);
   import pkdf_pkg::*;

   logic [ADDR_W-1:0] own_address_ff;
   logic [ADDR_W-1:0] group_address_ff;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_source_ff;
   logic [ADDR_W-1:0] s1_destination_ff;
   logic [NUM_W-1:0]  s1_number_ff;
   logic [TYPE_W-1:0] s1_type_ff;

   logic              rsp_valid_ff;
   logic [1:0]        verdict_ff;
   logic              start_ff;
   logic              instruction_ff;
   logic              distance_ff;
   logic              location_out_ff;

   logic              location_flag_ff;
   logic              location_flag_in;

   logic              advance;
   logic              addressed;
   logic              hit;
   logic              is_new;
   logic [1:0]        verdict_in;
   key_type           key;
   lookup_type        lookup;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= OWN_ADDRESS_RESET;
         group_address_ff <= GROUP_ADDRESS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:   own_address_ff   <= csr_data;
            CSR_GROUP_ADDRESS: group_address_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the result register is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_source_ff      <= req_source_address;
         s1_destination_ff <= req_destination_address;
         s1_number_ff      <= req_packet_number;
         s1_type_ff        <= req_message_type;
      end
   end

   // Destination check and history lookup.
   assign addressed = (s1_destination_ff == own_address_ff) ||
                      (s1_destination_ff == group_address_ff);
   assign key       = {s1_source_ff, s1_number_ff};
   assign lookup    = '{fire: s1_valid_ff && advance, addressed: addressed};

   pkdf_history u_history (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .key    (key),
      .hit    (hit)
   );

   assign is_new = addressed && !hit;

   always_comb begin
      priority if (!addressed) begin
         verdict_in = VERDICT_NOT_ADDRESSED;
      end else if (hit) begin
         verdict_in = VERDICT_DUPLICATE;
      end else begin
         verdict_in = VERDICT_NEW;
      end
   end

   // A new location request sets the sticky flag.
   assign location_flag_in = location_flag_ff ||
                             (is_new && (s1_type_ff == TYPE_LOCATION));

   always_ff @(posedge clock) begin
      if (reset) begin
         location_flag_ff <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         location_flag_ff <= location_flag_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         verdict_ff      <= verdict_in;
         start_ff        <= is_new && (s1_type_ff == TYPE_LOCATION);
         instruction_ff  <= is_new && (s1_type_ff == TYPE_INSTRUCTION);
         distance_ff     <= is_new && (s1_type_ff == TYPE_DISTANCE);
         location_out_ff <= location_flag_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_start_location   = start_ff;
   assign rsp_instruction_seen = instruction_ff;
   assign rsp_distance_seen    = distance_ff;
   assign rsp_location_enabled = location_out_ff;

endmodule

// File: sv/pkdf_history.sv
// ----------------------------------------------------------------------------
// Packet dedup history ring
// Holds the recent keys with valid bits, compares a key against all valid
// entries at once and stores a new key at the ring pointer.
// ----------------------------------------------------------------------------
module pkdf_history (
   input  logic                 clock,
   input  logic                 reset,
   input  pkdf_pkg::lookup_type lookup,
   input  pkdf_pkg::key_type    key,
   output logic                 hit
);
   import pkdf_pkg::*;

   key_type                  key_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [PTR_W-1:0]         ptr_ff;
   logic [PTR_W-1:0]         ptr_in;
   logic [HISTORY_DEPTH-1:0] match;
   logic                     write_en;

   // Compare the key with every entry; empty slots never match.
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
      end
   end

   assign hit      = |match;
   assign write_en = lookup.fire && lookup.addressed && !hit;

   // The pointer advances after each store and wraps at the ring depth.
   always_comb begin
      if (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (write_en) begin
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   // Key storage needs no reset: an entry is only read once marked valid.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (write_en && (ptr_ff == PTR_W'(i))) begin
            key_ff[i] <= key;
         end
      end
   end

endmodule

// File: sv/pkdf_checker.sv
// ----------------------------------------------------------------------------
// Packet dedup checker
// Watches the top-level ports and checks the result fields over time.
// ----------------------------------------------------------------------------
module pkdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_verdict,
   input logic       rsp_start_location,
   input logic       rsp_instruction_seen,
   input logic       rsp_distance_seen,
   input logic       rsp_location_enabled
);
   import pkdf_pkg::*;

   // A stalled result holds its verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("Stalled result changed.");

   // Type flags appear only on new packets.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict != VERDICT_NEW) |->
         !rsp_start_location && !rsp_instruction_seen && !rsp_distance_seen)
      else $error("Flag raised on a packet that is not new.");

   // At most one type flag per result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $onehot0({rsp_start_location, rsp_instruction_seen, rsp_distance_seen}))
      else $error("More than one type flag raised.");

   // A location start always leaves the location enable set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_location |-> rsp_location_enabled)
      else $error("Location start without location enable.");

endmodule

bind packet_dedup_address_filter pkdf_checker u_pkdf_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet dedup address filter testbench
// Streams packet headers through the filter under changing address settings
// and random idling on both channels. Every result is checked field by field
// against a predictor that tracks the history ring, the ring pointer and the
// sticky location flag.
// ----------------------------------------------------------------------------
module tb;
   import pkdf_pkg::*;

   localparam int MAX_CYCLES    = 300000;
   localparam int SEGMENT_ITEMS = 335;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 6;
   localparam int POOL_SIZE     = 32;
   localparam int SEGMENTS      = 6;

   // Index past the end of the register list; writes to it are ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] destination;
      logic [NUM_W-1:0]  number;
      logic [TYPE_W-1:0] msg_type;
   } header_type;

   typedef struct {
      logic [1:0] verdict;
      logic       start_location;
      logic       instruction_seen;
      logic       distance_seen;
      logic       location_enabled;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ADDR_W-1:0]      req_source_address = '0;
   logic [ADDR_W-1:0]      req_destination_address = '0;
   logic [NUM_W-1:0]       req_packet_number = '0;
   logic [TYPE_W-1:0]      req_message_type = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_verdict;
   logic                   rsp_start_location;
   logic                   rsp_instruction_seen;
   logic                   rsp_distance_seen;
   logic                   rsp_location_enabled;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]      csr_data = '0;

   // Headers waiting to be sent and verdicts waiting to arrive.
   header_type  header_queue[$];
   verdict_type verdict_queue[$];

   // Predictor state.
   logic [ADDR_W-1:0] accept_own;
   logic [ADDR_W-1:0] accept_group;
   key_type           seen_key [HISTORY_DEPTH];
   logic              seen_valid [HISTORY_DEPTH];
   int                next_slot;
   logic              locate_flag;

   // Keys reused often so that duplicates and ring evictions occur.
   logic [ADDR_W-1:0] pool_source [POOL_SIZE];
   logic [NUM_W-1:0]  pool_number [POOL_SIZE];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   packet_dedup_address_filter i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_source_address      (req_source_address),
      .req_destination_address (req_destination_address),
      .req_packet_number       (req_packet_number),
      .req_message_type        (req_message_type),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_verdict             (rsp_verdict),
      .rsp_start_location      (rsp_start_location),
      .rsp_instruction_seen    (rsp_instruction_seen),
      .rsp_distance_seen       (rsp_distance_seen),
      .rsp_location_enabled    (rsp_location_enabled),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Works out the verdict for one accepted header and advances the history.
   function automatic verdict_type filter_header(header_type h);
      verdict_type v;
      key_type     key;
      logic        known;
      key   = {h.source, h.number};
      known = 1'b0;
      v.verdict          = VERDICT_NOT_ADDRESSED;
      v.start_location   = 1'b0;
      v.instruction_seen = 1'b0;
      v.distance_seen    = 1'b0;
      if (h.destination == accept_own || h.destination == accept_group) begin
         // Only entries written since reset take part in the compare.
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (seen_valid[i] && seen_key[i] == key)
               known = 1'b1;
         end
         if (known) begin
            v.verdict = VERDICT_DUPLICATE;
         end else begin
            v.verdict = VERDICT_NEW;
            seen_key[next_slot]   = key;
            seen_valid[next_slot] = 1'b1;
            next_slot = (next_slot + 1 == HISTORY_DEPTH) ? 0 : next_slot + 1;
            if (h.msg_type == TYPE_LOCATION) begin
               v.start_location = 1'b1;
               locate_flag      = 1'b1;
            end else if (h.msg_type == TYPE_INSTRUCTION) begin
               v.instruction_seen = 1'b1;
            end else if (h.msg_type == TYPE_DISTANCE) begin
               v.distance_seen = 1'b1;
            end
         end
      end
      v.location_enabled = locate_flag;
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] random_ascii_address();
      logic [ADDR_W-1:0] a;
      for (int i = 0; i < 4; i++)
         a[8*i +: 8] = 8'($urandom_range(8'h7e, 8'h20));
      return a;
   endfunction

   // Mostly addressed headers built from the key pool; the rest is noise.
   function automatic header_type make_header(logic [ADDR_W-1:0] own,
                                              logic [ADDR_W-1:0] group);
      header_type h;
      int         pick;
      int         slot;
      pick = $urandom_range(99);
      if (pick < 40)
         h.destination = own;
      else if (pick < 80)
         h.destination = group;
      else
         h.destination = $urandom;
      slot = $urandom_range(POOL_SIZE - 1);
      pick = $urandom_range(99);
      if (pick < 70) begin
         h.source = pool_source[slot];
         h.number = pool_number[slot];
      end else if (pick < 85) begin
         h.source = pool_source[slot];
         h.number = 16'($urandom);
      end else begin
         h.source = $urandom;
         h.number = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 25)
         h.msg_type = TYPE_LOCATION;
      else if (pick < 45)
         h.msg_type = TYPE_INSTRUCTION;
      else if (pick < 65)
         h.msg_type = TYPE_DISTANCE;
      else
         h.msg_type = 8'($urandom);
      return h;
   endfunction

   task automatic queue_header(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                               logic [NUM_W-1:0] num, logic [TYPE_W-1:0] typ);
      header_type h;
      h.source      = src;
      h.destination = dst;
      h.number      = num;
      h.msg_type    = typ;
      header_queue.push_back(h);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request is sent and answered, then lets the pipe drain.
   // The check runs on the falling edge, once the driver's updates have settled.
   task automatic wait_for_idle();
      while (header_queue.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Predictor reset and register writes as the block sees them.
   always @(posedge clock) begin
      if (reset) begin
         accept_own   = OWN_ADDRESS_RESET;
         accept_group = GROUP_ADDRESS_RESET;
         for (int i = 0; i < HISTORY_DEPTH; i++)
            seen_valid[i] = 1'b0;
         next_slot   = 0;
         locate_flag = 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_ADDRESS:   accept_own   = csr_data;
            CSR_GROUP_ADDRESS: accept_group = csr_data;
            default: ;
         endcase
      end
   end

   // Request driver: predicts each accepted request, then offers the next one.
   always @(posedge clock) begin : driver
      header_type h;
      header_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            h.source      = req_source_address;
            h.destination = req_destination_address;
            h.number      = req_packet_number;
            h.msg_type    = req_message_type;
            verdict_queue.push_back(filter_header(h));
         end
         if (!req_valid || !req_stall) begin
            if (header_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = header_queue.pop_front();
               req_valid               <= 1'b1;
               req_source_address      <= nxt.source;
               req_destination_address <= nxt.destination;
               req_packet_number       <= nxt.number;
               req_message_type        <= nxt.msg_type;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted result with the oldest verdict.
   always @(posedge clock) begin : monitor
      verdict_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: verdict %0d", rsp_verdict);
         end else begin
            exp_v = verdict_queue.pop_front();
            if (rsp_verdict !== exp_v.verdict
                || rsp_start_location !== exp_v.start_location
                || rsp_instruction_seen !== exp_v.instruction_seen
                || rsp_distance_seen !== exp_v.distance_seen
                || rsp_location_enabled !== exp_v.location_enabled) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"mismatch: expected v=%0d sl=%b is=%b ds=%b le=%b,",
                            " got v=%0d sl=%b is=%b ds=%b le=%b"},
                           exp_v.verdict, exp_v.start_location, exp_v.instruction_seen,
                           exp_v.distance_seen, exp_v.location_enabled,
                           rsp_verdict, rsp_start_location, rsp_instruction_seen,
                           rsp_distance_seen, rsp_location_enabled);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: directed headers, then random segments under several settings.
   initial begin : stimulus
      logic [ADDR_W-1:0] own;
      logic [ADDR_W-1:0] group;
      own   = OWN_ADDRESS_RESET;
      group = GROUP_ADDRESS_RESET;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_source[i] = random_ascii_address();
         pool_number[i] = {8'($urandom_range(8'h39, 8'h30)), 8'($urandom_range(8'h39, 8'h30))};
      end
      @(negedge reset);
      send_idle_pct  = 30;
      recv_stall_pct = 73;

      // Directed part, with the addresses as they come out of reset.
      queue_header(32'h3030_3032, own, 16'h3031, TYPE_LOCATION);
      queue_header(32'h3030_3032, own, 16'h3031, TYPE_LOCATION);
      queue_header(32'h3030_3032, group, 16'h3032, TYPE_INSTRUCTION);
      queue_header(32'h3030_3032, group, 16'h3033, TYPE_DISTANCE);
      queue_header(32'h3030_3032, group, 16'h3033, TYPE_INSTRUCTION);
      queue_header(32'h3030_3032, 32'h0000_0000, 16'h3034, TYPE_LOCATION);
      queue_header(32'h3030_3032, 32'hffff_ffff, 16'h3035, TYPE_DISTANCE);
      queue_header(32'h3030_3032, own, 16'h3034, 8'h5a);
      // An all-zero key must not match the empty history slots.
      queue_header(32'h0000_0000, own, 16'h0000, 8'h00);
      queue_header(32'h0000_0000, group, 16'h0000, TYPE_LOCATION);
      queue_header(32'hffff_ffff, own, 16'hffff, 8'hff);
      queue_header(32'hffff_ffff, group, 16'hffff, TYPE_DISTANCE);
      queue_header(32'hffff_fffe, own, 16'hffff, TYPE_INSTRUCTION);
      queue_header(32'hffff_ffff, own, 16'hfffe, TYPE_DISTANCE);
      queue_header(32'h3030_3031, own ^ 32'h0000_0001, 16'h3031, TYPE_LOCATION);
      queue_header(32'h3030_3031, group ^ 32'h8000_0000, 16'h3031, TYPE_LOCATION);
      queue_header(32'h3130_3033, own, 16'h3939, 8'h36);
      queue_header(32'h3130_3033, own, 16'h3939, 8'h37);
      queue_header(32'h3130_3033, group, 16'h3938, 8'h42);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_idle();
         case (seg)
            0: begin
               own = 32'h0000_0000;
               group = 32'hffff_ffff;
            end
            1: begin
               own = 32'hffff_ffff;
               group = 32'h0000_0000;
            end
            2: begin
               own = random_ascii_address();
               group = own;
            end
            3: begin
               own = random_ascii_address();
               group = $urandom;
            end
            4: begin
               own = OWN_ADDRESS_RESET;
               group = GROUP_ADDRESS_RESET;
            end
            default: begin
               own = random_ascii_address();
               group = random_ascii_address();
            end
         endcase
         write_register(CSR_OWN_ADDRESS, own);
         write_register(CSR_GROUP_ADDRESS, group);
         // A write past the register list must change nothing.
         write_register(CSR_SPARE_INDEX, $urandom);
         if (seg < 2) begin
            send_idle_pct  = 30;
            recv_stall_pct = 73;
         end else if (seg < 4) begin
            send_idle_pct  = 73;
            recv_stall_pct = 30;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         for (int i = 0; i < SEGMENT_ITEMS; i++)
            header_queue.push_back(make_header(own, group));
      end

      wait_for_idle();
      if (mismatch_count == 0 && verdict_queue.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
